// ===== src/mpts_pkg.sv =====
// Package with types and constants for the max-perimeter triangle search.
package mpts_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned PerimW = 19;
  // The squared distance fits in 33 bits and its root in 17 bits.
  localparam int unsigned SqW    = 34;
  localparam int unsigned RootW  = 17;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RDA,
    ST_RDB,
    ST_DIFF,
    ST_SQ,
    ST_START,
    ST_ROOT,
    ST_ACC,
    ST_NEXT,
    ST_DONE
  } state_e;

  // Status from the square-root unit.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RootW-1:0] root;
  } root_stat_t;

endpackage

// ===== src/mpts_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module mpts_isqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [mpts_pkg::SqW-1:0] value_i,
  output mpts_pkg::root_stat_t    stat_o
);
  import mpts_pkg::*;

  localparam int unsigned CntW = $clog2(RootW + 1);

  logic [SqW-1:0]   rem_q, rem_d;
  logic [SqW-1:0]   val_q, val_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [SqW+1:0]   trial;
  logic [SqW+1:0]   rem_sh;

  // Restoring digit recurrence: two radicand bits enter per step.
  always_comb begin
    rem_sh = {rem_q, val_q[SqW-1 -: 2]};
    trial  = {{(SqW + 2 - RootW - 2){1'b0}}, root_q, 2'b01};
    rem_d  = rem_q;
    val_d  = val_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      val_d  = value_i;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[SqW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = SqW'(rem_sh - trial);
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = SqW'(rem_sh);
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    val_q  <= val_d;
    root_q <= root_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q, root: root_q};

endmodule

// ===== src/max_perimeter_triangle_search.sv =====
// Top level of the max-perimeter triangle search.
//
//  channel | signals                                          | transfer when
//  in      | in_valid_i in_ready_o x/y_coord_i last_point_i   | valid and ready
//  out     | out_valid_o out_ready_i indices perimeter found  | valid and ready
//
// Points load one per cycle. After the last point each triple i<j<k is tested
// with three distances; each distance takes two store reads, a difference, a
// square, a start of the root unit, a wait for its done, and an accumulate,
// and each triple ends with a step of the walk. The store needs no clearing
// after reset. Input stays stalled during the search and while a result
// waits.
module max_perimeter_triangle_search #(
  parameter int unsigned POINT_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [mpts_pkg::CoordW-1:0] x_coord_i,
  input  logic signed [mpts_pkg::CoordW-1:0] y_coord_i,
  input  logic                          last_point_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mpts_pkg::IdxW-1:0]     first_index_o,
  output logic [mpts_pkg::IdxW-1:0]     second_index_o,
  output logic [mpts_pkg::IdxW-1:0]     third_index_o,
  output logic [mpts_pkg::PerimW-1:0]   best_perimeter_o,
  output logic                          found_o
);
  import mpts_pkg::*;

  localparam int unsigned AddrW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(POINT_DEPTH + 1);
  localparam int unsigned SumW  = RootW + 2;

  logic [CoordW-1:0] mem_x [POINT_DEPTH];
  logic [CoordW-1:0] mem_y [POINT_DEPTH];

  state_e state_q, state_d;
  logic [CntW-1:0] n_q;
  logic [CntW-1:0] i_q, j_q, k_q;
  logic [1:0]      leg_q;
  logic [AddrW-1:0] ra, rb;
  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [CoordW:0]   dx, dy;
  logic [CoordW-1:0]        adx_q, ady_q;
  logic [2*CoordW-1:0]      sqx, sqy;
  logic [SqW-1:0]  sq_q;
  logic [SumW-1:0] sum_q;
  logic [SumW-1:0] best_q;
  logic            have_q;
  logic [IdxW-1:0] bi_q, bj_q, bk_q;
  logic            ovalid_q;
  logic            root_start;
  logic            walk_done;
  root_stat_t      rstat;
  logic            in_xfer;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_LOAD) && !ovalid_q;

  // Leg 0 is (i,j), leg 1 is (j,k), leg 2 is (i,k).
  always_comb begin
    unique case (leg_q)
      2'd0:    begin ra = i_q[AddrW-1:0]; rb = j_q[AddrW-1:0]; end
      2'd1:    begin ra = j_q[AddrW-1:0]; rb = k_q[AddrW-1:0]; end
      default: begin ra = i_q[AddrW-1:0]; rb = k_q[AddrW-1:0]; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && (n_q < CntW'(POINT_DEPTH))) begin
      mem_x[n_q[AddrW-1:0]] <= x_coord_i;
      mem_y[n_q[AddrW-1:0]] <= y_coord_i;
    end
    if (state_q == ST_RDA) begin
      ax_q <= mem_x[ra];
      ay_q <= mem_y[ra];
    end
    if (state_q == ST_RDB) begin
      bx_q <= mem_x[rb];
      by_q <= mem_y[rb];
    end
  end

  // The walk ends when no triple follows the current one.
  assign walk_done = !(k_q + 1'b1 < n_q) && !(j_q + 2'd2 < n_q) && !(i_q + 2'd3 < n_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_xfer && last_point_i) state_d = ST_NEXT;
      ST_RDA:   state_d = ST_RDB;
      ST_RDB:   state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_SQ;
      ST_SQ:    state_d = ST_START;
      ST_START: state_d = ST_ROOT;
      ST_ROOT:  if (rstat.done) state_d = ST_ACC;
      ST_ACC:   state_d = (leg_q == 2'd2) ? ST_NEXT : ST_RDA;
      ST_NEXT:  state_d = walk_done ? ST_DONE : ST_RDA;
      ST_DONE:  state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // The root starts once the sum of squares is registered.
  assign root_start = (state_q == ST_START);

  mpts_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_start),
    .value_i(sq_q),
    .stat_o (rstat)
  );

  always_comb begin
    dx  = (CoordW+1)'(ax_q) - (CoordW+1)'(bx_q);
    dy  = (CoordW+1)'(ay_q) - (CoordW+1)'(by_q);
    sqx = adx_q * adx_q;
    sqy = ady_q * ady_q;
  end

  // Magnitudes of the differences fit in 16 bits, so the squares are 16 by 16.
  always_ff @(posedge clk_i) begin
    adx_q <= dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
    ady_q <= dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SQ) begin
      sq_q <= SqW'(sqx) + SqW'(sqy);
    end
  end

  // Counters, triple walk and best tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      n_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      leg_q    <= '0;
      sum_q    <= '0;
      best_q   <= '0;
      have_q   <= 1'b0;
      bi_q     <= '0;
      bj_q     <= '0;
      bk_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (in_xfer) begin
            if (n_q < CntW'(POINT_DEPTH)) n_q <= n_q + 1'b1;
            if (last_point_i) begin
              i_q    <= '0;
              j_q    <= CntW'(1);
              k_q    <= CntW'(1);
              leg_q  <= 2'd2;
              have_q <= 1'b0;
              best_q <= '0;
              bi_q   <= '0;
              bj_q   <= '0;
              bk_q   <= '0;
            end
          end
        end
        ST_ACC: begin
          if (leg_q == 2'd0) sum_q <= SumW'(rstat.root);
          else               sum_q <= sum_q + SumW'(rstat.root);
          if (leg_q == 2'd2) begin
            if (!have_q || (sum_q + SumW'(rstat.root)) > best_q) begin
              have_q <= 1'b1;
              best_q <= sum_q + SumW'(rstat.root);
              bi_q   <= i_q[IdxW-1:0];
              bj_q   <= j_q[IdxW-1:0];
              bk_q   <= k_q[IdxW-1:0];
            end
          end else begin
            leg_q <= leg_q + 1'b1;
          end
        end
        ST_NEXT: begin
          // Step to the next triple in lexicographic order, or finish.
          leg_q <= 2'd0;
          if (k_q + 1'b1 < n_q) begin
            k_q <= k_q + 1'b1;
          end else if (j_q + 2'd2 < n_q) begin
            j_q <= j_q + 1'b1;
            k_q <= j_q + 2'd2;
          end else if (i_q + 2'd3 < n_q) begin
            i_q <= i_q + 1'b1;
            j_q <= i_q + 2'd2;
            k_q <= i_q + 2'd3;
          end else begin
            ovalid_q <= 1'b1;
            n_q      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o      = ovalid_q;
  assign first_index_o    = bi_q;
  assign second_index_o   = bj_q;
  assign third_index_o    = bk_q;
  assign best_perimeter_o = best_q[PerimW-1:0];
  assign found_o          = have_q;

endmodule

// ===== src/max_perimeter_triangle_search_chk.sv =====
// Port-level checker for the max-perimeter triangle search, with its bind.
module max_perimeter_triangle_search_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [mpts_pkg::IdxW-1:0]   first_index_o,
  input logic [mpts_pkg::IdxW-1:0]   second_index_o,
  input logic [mpts_pkg::IdxW-1:0]   third_index_o,
  input logic [mpts_pkg::PerimW-1:0] best_perimeter_o,
  input logic                        found_o
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready while result waits");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |->
      (first_index_o < second_index_o) && (second_index_o < third_index_o))
    else $error("indices out of order");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (best_perimeter_o == '0) && (first_index_o == '0))
    else $error("empty result not zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(best_perimeter_o))
    else $error("result dropped");

endmodule

bind max_perimeter_triangle_search max_perimeter_triangle_search_chk u_chk (.*);

// ===== test/max_perimeter_triangle_search_tb.sv =====
// Testbench for the max-perimeter triangle search: directed and random point sets checked against a predictor.
`timescale 1ns / 1ps

module max_perimeter_triangle_search_tb;
  import mpts_pkg::*;

  localparam int unsigned WatchdogLimit = 200000;
  localparam int unsigned TargetPoints = 1750;
  localparam int unsigned StoreDepth = 1024;

  typedef struct {
    logic [IdxW-1:0]   first_idx;
    logic [IdxW-1:0]   second_idx;
    logic [IdxW-1:0]   third_idx;
    logic [PerimW-1:0] perimeter;
    logic              found;
  } triangle_t;

  class triangle_scoreboard;
    longint set_x[$];
    longint set_y[$];
    triangle_t expected_q[$];
    int unsigned errors;
    int unsigned checked;

    static function automatic logic [RootW-1:0] floor_root(logic [SqW-1:0] v);
      logic [RootW-1:0] r;
      logic [RootW-1:0] t;
      r = '0;
      for (int b = RootW - 1; b >= 0; b--) begin
        t = r | (RootW'(1) << b);
        if (longint'(t) * longint'(t) <= longint'(v)) begin
          r = t;
        end
      end
      return r;
    endfunction

    function automatic logic [RootW-1:0] span(int a, int b);
      longint dx;
      longint dy;
      dx = set_x[a] - set_x[b];
      dy = set_y[a] - set_y[b];
      return floor_root(SqW'(dx * dx + dy * dy));
    endfunction

    // Notes an accepted point; the point marked last closes the set.
    function void note_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                             logic last);
      triangle_t t;
      int n;
      logic [PerimW+1:0] p;
      // A point arriving at a full store is dropped.
      if (set_x.size() < StoreDepth) begin
        set_x.push_back(longint'(x));
        set_y.push_back(longint'(y));
      end
      if (!last) begin
        return;
      end
      t = '{default: '0};
      n = set_x.size();
      for (int i = 0; i + 2 < n; i++) begin
        for (int j = i + 1; j + 1 < n; j++) begin
          for (int k = j + 1; k < n; k++) begin
            p = span(i, j) + span(j, k) + span(i, k);
            // Strictly greater only, so the first of tied triples stays.
            if (!t.found || p > t.perimeter) begin
              t.found = 1'b1;
              t.perimeter = PerimW'(p);
              t.first_idx = IdxW'(i);
              t.second_idx = IdxW'(j);
              t.third_idx = IdxW'(k);
            end
          end
        end
      end
      expected_q.push_back(t);
      set_x.delete();
      set_y.delete();
    endfunction

    function void check(triangle_t got);
      triangle_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result idx %0d/%0d/%0d perim %0d found %0d", $time,
                 got.first_idx, got.second_idx, got.third_idx, got.perimeter, got.found);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.first_idx !== e.first_idx) begin
        $display("%0t: first_index expected %0d actual %0d", $time, e.first_idx,
                 got.first_idx);
        errors++;
      end
      if (got.second_idx !== e.second_idx) begin
        $display("%0t: second_index expected %0d actual %0d", $time, e.second_idx,
                 got.second_idx);
        errors++;
      end
      if (got.third_idx !== e.third_idx) begin
        $display("%0t: third_index expected %0d actual %0d", $time, e.third_idx,
                 got.third_idx);
        errors++;
      end
      if (got.perimeter !== e.perimeter) begin
        $display("%0t: best_perimeter expected %0d actual %0d", $time, e.perimeter,
                 got.perimeter);
        errors++;
      end
      if (got.found !== e.found) begin
        $display("%0t: found expected %0d actual %0d", $time, e.found, got.found);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [CoordW-1:0] x_coord_i;
  logic signed [CoordW-1:0] y_coord_i;
  logic                     last_point_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [IdxW-1:0]          first_index_o;
  logic [IdxW-1:0]          second_index_o;
  logic [IdxW-1:0]          third_index_o;
  logic [PerimW-1:0]        best_perimeter_o;
  logic                     found_o;

  max_perimeter_triangle_search u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .x_coord_i       (x_coord_i),
    .y_coord_i       (y_coord_i),
    .last_point_i    (last_point_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .first_index_o   (first_index_o),
    .second_index_o  (second_index_o),
    .third_index_o   (third_index_o),
    .best_perimeter_o(best_perimeter_o),
    .found_o         (found_o)
  );

  triangle_scoreboard sb = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;
  bit          hold_done;
  int unsigned idle_cycles;
  int unsigned points_sent;
  int unsigned sets_sent;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    out_ready_i = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        out_ready_i <= 1'b0;
        for (int c = 0; c < 3000; c++) begin
          @(posedge clk_i);
        end
        hold_done = 1'b1;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check('{first_index_o, second_index_o, third_index_o, best_perimeter_o, found_o});
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.expected_q.size());
      $display("max_perimeter_triangle_search_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                            logic last);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    x_coord_i    <= x;
    y_coord_i    <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_point(x, y, last);
    points_sent++;
    if (last) begin
      sets_sent++;
    end
  endtask

  function automatic logic signed [CoordW-1:0] pick_coord(int unsigned style);
    case (style)
      0: return CoordW'($urandom);
      1: return CoordW'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return CoordW'($signed($urandom_range(2048)) - 1024);
    endcase
  endfunction

  task automatic send_random_set();
    int unsigned n;
    int unsigned style;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) n = $urandom_range(2, 1);
    else if (r < 95) n = $urandom_range(7, 3);
    else n = $urandom_range(12, 8);
    style = $urandom_range(3);
    for (int p = 0; p < n; p++) begin
      send_point(pick_coord(style), pick_coord(style), p == n - 1);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    x_coord_i = '0;
    y_coord_i = '0;
    last_point_i = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b0;
    points_sent = 0;
    sets_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sets of one and two points give no triangle.
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b1);
    // The four corners of the whole plane.
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    // Coincident points tie at zero, so the first triple wins.
    repeat (3) send_point(16'sh0100, -16'sh0100, 1'b0);
    send_point(16'sh0100, -16'sh0100, 1'b1);
    // Square of side 0x100: every triple has the same perimeter.
    send_point(16'sh0000, 16'sh0000, 1'b0);
    send_point(16'sh0100, 16'sh0000, 1'b0);
    send_point(16'sh0100, 16'sh0100, 1'b0);
    send_point(16'sh0000, 16'sh0100, 1'b1);
    // Collinear points.
    send_point(-16'sh0300, 16'sh0000, 1'b0);
    send_point(16'sh0000, 16'sh0000, 1'b0);
    send_point(16'sh0500, 16'sh0000, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; hold_request = 1'b1; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      while (points_sent < (phase + 1) * TargetPoints / 4) begin
        send_random_set();
      end
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Sent %0d points in %0d sets; %0d results checked over four stall profiles.",
             points_sent, sets_sent, sb.checked);
    if (sb.errors == 0) begin
      $display("max_perimeter_triangle_search_tb: PASS");
    end else begin
      $display("max_perimeter_triangle_search_tb: FAIL");
    end
    $finish;
  end

endmodule
